FILE: src/bilinear_texture_sampler_top_macros.svh
// Assertion macros used by the checker file.
`ifndef BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bts same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bts next-cycle check failed");

// Next-cycle implication that is also checked during reset.
`define BTS_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bts reset check failed");

`endif

FILE: src/bts_pkg.sv
package bts_pkg;

  localparam int MAX_DIM_LOG2_DEF = 8;
  localparam int WEIGHT_BITS_DEF  = 8;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;
  localparam int RGB_W      = 24;
  localparam int CH_W       = 8;
  localparam int OUT_CH_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_RESET = 256;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

  // Item kinds carried on tuser.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Fetch order of the four neighbors.
  localparam logic [1:0] PH_00 = 2'd0;
  localparam logic [1:0] PH_10 = 2'd1;
  localparam logic [1:0] PH_01 = 2'd2;
  localparam logic [1:0] PH_11 = 2'd3;

endpackage

FILE: src/bts_blend.sv
module bts_blend #(
  parameter int WEIGHT_BITS = bts_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_v,
  input  logic [bts_pkg::RGB_W-1:0]         c00,
  input  logic [bts_pkg::RGB_W-1:0]         c10,
  input  logic [bts_pkg::RGB_W-1:0]         c01,
  input  logic [bts_pkg::RGB_W-1:0]         c11,
  input  logic [WEIGHT_BITS-1:0]            fu,
  input  logic [WEIGHT_BITS-1:0]            fv,
  output logic                              out_v,
  output logic [bts_pkg::OUT_DATA_W-1:0]    out_rgb  // red, green, blue
);

  localparam int WW = WEIGHT_BITS + 1;
  localparam int TW = bts_pkg::CH_W + WW;
  localparam int SW = TW + WW;
  localparam int SH = 2 * WEIGHT_BITS - 8;
  localparam logic [WW-1:0] WONE = WW'(1) << WEIGHT_BITS;

  logic [TW-1:0]          top_r [3];
  logic [TW-1:0]          bot_r [3];
  logic [TW-1:0]          top_nxt [3];
  logic [TW-1:0]          bot_nxt [3];
  logic [WEIGHT_BITS-1:0] fv_r;
  logic                   s1_v_r;
  logic                   out_v_r;
  logic [bts_pkg::OUT_DATA_W-1:0] out_rgb_r;
  logic [bts_pkg::OUT_DATA_W-1:0] out_rgb_nxt;
  logic [WW-1:0]          wfu;
  logic [WW-1:0]          wfv;

  assign wfu = WONE - WW'(fu);
  assign wfv = WONE - WW'(fv_r);

  // Channel 0 is red, held in the top byte of a texel.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [bts_pkg::CH_W-1:0] a, b, c, d;
      a = c00[16 - 8*ch +: 8];
      b = c10[16 - 8*ch +: 8];
      c = c01[16 - 8*ch +: 8];
      d = c11[16 - 8*ch +: 8];
      top_nxt[ch] = TW'(a) * TW'(wfu) + TW'(b) * TW'(fu);
      bot_nxt[ch] = TW'(c) * TW'(wfu) + TW'(d) * TW'(fu);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [SW-1:0] sum;
      sum = SW'(top_r[ch]) * SW'(wfv) + SW'(bot_r[ch]) * SW'(fv_r);
      out_rgb_nxt[16*ch +: 16] = sum[SH +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_v;
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_r     <= top_nxt;
      bot_r     <= bot_nxt;
      fv_r      <= fv;
      out_rgb_r <= out_rgb_nxt;
    end
  end

  assign out_v   = out_v_r;
  assign out_rgb = out_rgb_r;

endmodule

FILE: src/bilinear_texture_sampler_top.sv
// Channel | Direction | Carries
// in_     | slave     | tuser: operation; tdata: texel x/y, red/green/blue, coord u, coord v
// out_    | master    | tdata: blended red, green, blue (8.8 each)
// cfg_    | write     | texture width (index 0), texture height (index 1)
//
// A write word takes one write of the single-port texture memory; a sample
// word takes four reads, one for each neighbor texel. A result passes
// through the read register and the blend registers before it reaches out_.
// The memory needs no clearing after reset. A result held on out_ stalls the
// whole datapath and in_tready drops until it is taken.
module bilinear_texture_sampler_top #(
  parameter int MAX_DIM_LOG2 = bts_pkg::MAX_DIM_LOG2_DEF,
  parameter int WEIGHT_BITS  = bts_pkg::WEIGHT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // x, y, red, green, blue, coord_u, coord_v
  input  logic [bts_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_red, out_green, out_blue
  output logic [bts_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DW    = MAX_DIM_LOG2;
  localparam int SZW   = MAX_DIM_LOG2 + 1;
  localparam int PW    = 16 + SZW;
  localparam int AW    = 2 * MAX_DIM_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam logic [15:0] DIM16 = 16'(1 << MAX_DIM_LOG2);

  logic [bts_pkg::CFG_DATA_W-1:0] width_r, height_r;
  logic [SZW-1:0]  size_w, size_h;
  logic [15:0]     w16, h16, effw, effh;

  logic            adv, accept, last;
  logic            active_r, active_nxt;
  logic [1:0]      phase_r;
  logic            op_r;
  logic [AW-1:0]   waddr_r;
  logic [bts_pkg::RGB_W-1:0] rgb_r;
  logic [PW-1:0]   pu_r, pv_r;
  logic [DW-1:0]   x0, y0, x1, y1, rx, ry;
  logic [SZW-1:0]  x0p, y0p;
  logic [15:0]     in_x16, in_y16;
  logic [AW-1:0]   mem_addr;

  logic [bts_pkg::RGB_W-1:0] mem [DEPTH];
  logic [bts_pkg::RGB_W-1:0] rdata_r;
  logic [bts_pkg::RGB_W-1:0] nb_r [3];
  logic            rd_v_r;
  logic [1:0]      rd_ph_r;
  logic [WEIGHT_BITS-1:0] fu_r, fv_r;
  logic            blend_v;

  // Out-of-range sizes saturate into 1..2^MAX_DIM_LOG2.
  assign w16  = 16'(width_r);
  assign h16  = 16'(height_r);
  assign effw = (w16 == 16'd0) ? 16'd1 : ((w16 > DIM16) ? DIM16 : w16);
  assign effh = (h16 == 16'd0) ? 16'd1 : ((h16 > DIM16) ? DIM16 : h16);
  assign size_w = effw[SZW-1:0];
  assign size_h = effh[SZW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bts_pkg::CFG_DATA_W'(bts_pkg::SIZE_RESET);
      height_r <= bts_pkg::CFG_DATA_W'(bts_pkg::SIZE_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bts_pkg::REG_TEX_WIDTH:  width_r  <= cfg_wdata;
        bts_pkg::REG_TEX_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign last      = (op_r == bts_pkg::OP_WRITE) || (phase_r == bts_pkg::PH_11);
  assign in_tready = adv && (!active_r || last);
  assign accept    = in_tvalid && in_tready;
  assign active_nxt = accept ? 1'b1 : (last ? 1'b0 : active_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= bts_pkg::PH_00;
    end else if (adv) begin
      active_r <= active_nxt;
      phase_r  <= accept ? bts_pkg::PH_00 : phase_r + 2'd1;
    end
  end

  assign in_x16 = {8'd0, in_tdata[7:0]};
  assign in_y16 = {8'd0, in_tdata[15:8]};

  // With the fractional coordinate c in [0,1), c*size lies in [0,size), so
  // the integer part is already the wrapped index and no modulo is needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser;
      waddr_r <= {in_y16[DW-1:0], in_x16[DW-1:0]};
      rgb_r   <= {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]};
      pu_r    <= PW'(in_tdata[55:40]) * PW'(size_w);
      pv_r    <= PW'(in_tdata[79:64]) * PW'(size_h);
    end
  end

  assign x0  = pu_r[16 +: DW];
  assign y0  = pv_r[16 +: DW];
  assign x0p = SZW'(x0) + SZW'(1);
  assign y0p = SZW'(y0) + SZW'(1);
  assign x1  = (x0p == size_w) ? '0 : x0p[DW-1:0];
  assign y1  = (y0p == size_h) ? '0 : y0p[DW-1:0];

  always_comb begin
    case (phase_r)
      bts_pkg::PH_00: begin rx = x0; ry = y0; end
      bts_pkg::PH_10: begin rx = x1; ry = y0; end
      bts_pkg::PH_01: begin rx = x0; ry = y1; end
      bts_pkg::PH_11: begin rx = x1; ry = y1; end
      default:        begin rx = x0; ry = y0; end
    endcase
    mem_addr = (op_r == bts_pkg::OP_WRITE) ? waddr_r : {ry, rx};
  end

  always_ff @(posedge clk) begin
    if (adv && active_r) begin
      if (op_r == bts_pkg::OP_WRITE) begin
        mem[mem_addr] <= rgb_r;
      end else begin
        rdata_r <= mem[mem_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (adv) begin
      rd_v_r <= active_r && (op_r == bts_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_ph_r <= phase_r;
      fu_r    <= pu_r[15 -: WEIGHT_BITS];
      fv_r    <= pv_r[15 -: WEIGHT_BITS];
      if (rd_v_r && (rd_ph_r != bts_pkg::PH_11)) begin
        nb_r[rd_ph_r] <= rdata_r;
      end
    end
  end

  // The last neighbor goes straight from the read register into the blend.
  assign blend_v = rd_v_r && (rd_ph_r == bts_pkg::PH_11);

  bts_blend #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (blend_v),
    .c00     (nb_r[0]),
    .c10     (nb_r[1]),
    .c01     (nb_r[2]),
    .c11     (rdata_r),
    .fu      (fu_r),
    .fv      (fv_r),
    .out_v   (out_tvalid),
    .out_rgb (out_tdata)
  );

endmodule

FILE: src/bts_checker.sv
`include "bilinear_texture_sampler_top_macros.svh"

module bts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bts_pkg::OUT_DATA_W-1:0]  out_tdata
);

  `BTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BTS_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `BTS_ASSERT_NEXT(a_sample_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser == bts_pkg::OP_SAMPLE), !in_tready)
  `BTS_ASSERT_RST(a_reset_quiet, clk, !rst_n, !out_tvalid)

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/tb_bilinear_texture_sampler_top.sv
module tb_bilinear_texture_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 256;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic                          op;
    logic [bts_pkg::IN_DATA_W-1:0] data;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bts_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [bts_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  word_t pending_words[$];
  logic [bts_pkg::OUT_DATA_W-1:0] expected_rgb[$];
  logic [bts_pkg::RGB_W-1:0] texels[DIM*DIM];
  bit written[DIM*DIM];
  int tex_w_reg = bts_pkg::SIZE_RESET;
  int tex_h_reg = bts_pkg::SIZE_RESET;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;

  bilinear_texture_sampler_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(input int r);
    if (r < 1) return 1;
    if (r > DIM) return DIM;
    return r;
  endfunction

  // Floor split of coord * size, with the integer part wrapped by true modulo.
  function automatic void split_axis(input int coord, input int size,
                                     output int i0, output int i1, output int wt);
    longint p;
    longint ip;
    p = longint'(coord) * size;
    ip = p >>> 16;
    i0 = int'(ip % size);
    if (i0 < 0) i0 += size;
    i1 = int'((ip + 1) % size);
    if (i1 < 0) i1 += size;
    wt = int'((p & 64'hFFFF) >> (16 - bts_pkg::WEIGHT_BITS_DEF));
  endfunction

  function automatic logic [bts_pkg::OUT_CH_W-1:0] mix_channel(input int c00, c10, c01, c11,
                                                              input int fu, fv);
    longint top;
    longint bot;
    longint sum;
    top = longint'(c00) * (256 - fu) + longint'(c10) * fu;
    bot = longint'(c01) * (256 - fu) + longint'(c11) * fu;
    sum = top * (256 - fv) + bot * fv;
    return bts_pkg::OUT_CH_W'(sum >> 8);
  endfunction

  function automatic logic [bts_pkg::OUT_DATA_W-1:0] sample_rgb(input int u, input int v);
    int x0, x1, y0, y1, fu, fv;
    logic [bts_pkg::RGB_W-1:0] t00, t10, t01, t11;
    logic [bts_pkg::OUT_DATA_W-1:0] rgb;
    split_axis(u, eff_size(tex_w_reg), x0, x1, fu);
    split_axis(v, eff_size(tex_h_reg), y0, y1, fv);
    t00 = texels[y0*DIM + x0];
    t10 = texels[y0*DIM + x1];
    t01 = texels[y1*DIM + x0];
    t11 = texels[y1*DIM + x1];
    for (int ch = 0; ch < 3; ch++) begin
      rgb[ch*16 +: 16] = mix_channel(t00[(2-ch)*8 +: 8], t10[(2-ch)*8 +: 8],
                                     t01[(2-ch)*8 +: 8], t11[(2-ch)*8 +: 8], fu, fv);
    end
    return rgb;
  endfunction

  function automatic logic [bts_pkg::IN_DATA_W-1:0] pack_word(input int x, y, r, g, b, u, v);
    return {v[23:0], u[23:0], b[7:0], g[7:0], r[7:0], y[7:0], x[7:0]};
  endfunction

  task automatic push_write(input int x, input int y, input int r, input int g,
                            input int b);
    word_t w;
    w.op = bts_pkg::OP_WRITE;
    w.data = pack_word(x, y, r, g, b, $urandom, $urandom);
    written[(y % DIM)*DIM + (x % DIM)] = 1'b1;
    pending_words.push_back(w);
  endtask

  // Writes any neighbor not yet stored, then queues the sample itself.
  task automatic push_sample(input int u, input int v);
    int x0, x1, y0, y1, fu, fv;
    int xs[2];
    int ys[2];
    word_t w;
    split_axis(u, eff_size(tex_w_reg), x0, x1, fu);
    split_axis(v, eff_size(tex_h_reg), y0, y1, fv);
    xs[0] = x0; xs[1] = x1; ys[0] = y0; ys[1] = y1;
    foreach (ys[j]) foreach (xs[i])
      if (!written[ys[j]*DIM + xs[i]])
        push_write(xs[i], ys[j], $urandom_range(255), $urandom_range(255),
                   $urandom_range(255));
    w.op = bts_pkg::OP_SAMPLE;
    w.data = pack_word($urandom, $urandom, $urandom, $urandom, $urandom, u, v);
    pending_words.push_back(w);
  endtask

  function automatic int rand_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return int'(signed'(24'($urandom)));
    if (sel < 6) return $urandom_range(131072) - 65536;
    return $urandom_range(16777215, 0) % 1048576 - 524288;
  endfunction

  task automatic write_reg(input logic [bts_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= bts_pkg::CFG_DATA_W'(val);
    if (idx == bts_pkg::REG_TEX_WIDTH) tex_w_reg = val;
    else tex_h_reg = val;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(bts_pkg::REG_TEX_WIDTH, w);
    write_reg(bts_pkg::REG_TEX_HEIGHT, h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && expected_rgb.size() == 0 && !in_tvalid);
    repeat (16) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [bts_pkg::OUT_CH_W-1:0] got,
                                 input logic [bts_pkg::OUT_CH_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver: predicts each accepted word, then offers the next one.
  always @(posedge clk) begin
    logic more;
    if (rst_n) begin
      more = in_tvalid;
      if (in_tvalid && in_tready) begin
        more = 1'b0;
        if (in_tuser == bts_pkg::OP_WRITE)
          texels[in_tdata[15:8]*DIM + in_tdata[7:0]] =
            {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]};
        else
          expected_rgb.push_back(sample_rgb(int'(signed'(in_tdata[63:40])),
                                            int'(signed'(in_tdata[87:64]))));
      end
      if (!more && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        word_t w;
        w = pending_words.pop_front();
        in_tuser <= w.op;
        in_tdata <= w.data;
        more = 1'b1;
      end
      in_tvalid <= more;
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    logic [bts_pkg::OUT_DATA_W-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch("unexpected word", out_tdata[15:0], '0);
        end else begin
          want = expected_rgb.pop_front();
          if (out_tdata[15:0] !== want[15:0]) report_mismatch("red", out_tdata[15:0], want[15:0]);
          if (out_tdata[31:16] !== want[31:16])
            report_mismatch("green", out_tdata[31:16], want[31:16]);
          if (out_tdata[47:32] !== want[47:32])
            report_mismatch("blue", out_tdata[47:32], want[47:32]);
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, so the pipeline fills and in_tready drops.
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    else if (hold_go) hold_left <= 300;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** bilinear_texture_sampler_top: FAILED **");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int sizes[6][2];
    int idle_modes[4][2];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset sizes, color extremes, coordinate extremes and fractions.
    push_write(255, 255, 255, 255, 255);
    push_write(0, 0, 0, 0, 0);
    push_write(0, 255, 255, 0, 170);
    push_write(255, 0, 0, 255, 85);
    push_sample(0, 0);
    push_sample(-1, -1);
    push_sample(-65536, 0);
    push_sample(65535, 65535);
    push_sample(8388607, 8388607);
    push_sample(-8388608, -8388608);
    push_sample(8388607, -8388608);
    push_sample(32768, -32768);
    push_sample(16777, 128);
    push_sample(255, 256);
    hold_go = 1'b1;
    repeat (4) @(posedge clk);
    hold_go = 1'b0;
    drain();

    sizes = '{'{1, 1}, '{0, 511}, '{3, 5}, '{256, 256}, '{300, 17}, '{2, 256}};
    idle_modes = '{'{0, 0}, '{86, 0}, '{0, 86}, '{20, 20}};
    foreach (sizes[p]) begin
      set_size(sizes[p][0], sizes[p][1]);
      send_idle_pct = idle_modes[p % 4][0];
      recv_stall_pct = idle_modes[p % 4][1];
      if (p == 3) begin
        hold_go = 1'b1;
        repeat (4) @(posedge clk);
        hold_go = 1'b0;
      end
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(4) == 0)
          push_write($urandom_range(255), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255), $urandom_range(255));
        else
          push_sample(rand_coord(), rand_coord());
      end
      drain();
    end

    if (errors == 0) begin
      $display("** bilinear_texture_sampler_top: PASSED **");
    end else begin
      $display("** bilinear_texture_sampler_top: FAILED **");
    end
    $finish;
  end

endmodule
